@@ rtl/stq_pkg.sv @@
// Shared types and constants for the sleep timer queue.
// No dependencies; imported by the controller, the datapath and the top level.
package stq_pkg;

   localparam int NOW_W      = 48;
   localparam int ID_W       = 6;
   localparam int SECS_W     = 16;
   localparam int SLEEPERS_W = 7;
   localparam int DELAY_W    = 36;
   localparam int USEC_W     = 20;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 16;

   localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);

   // request kinds carried on tuser
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_SLEEP = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load;         // capture the accepted request
      logic tick_commit;  // retire a tick: pop the head if due, post result
      logic ins_commit;   // retire a sleep: insert or flag full, post result
   } stq_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_sleep;     // held request is a sleep request
      logic out_free;     // result register can take a new result this cycle
   } stq_stat_type;

endpackage

@@ rtl/sleep_timer_queue.sv @@
// Sleep timer queue: wake times sorted ascending, with head-of-queue wakeup.
// A tick posts its response from the multiply state, a sleep request from the insert
// state after add; either waits there while the response register is full. The
// sequencer holds one request at a time and takes no new one until it commits.
// Reset (synchronous, active high) empties the queue and the response register.
// Depends on stq_pkg, stq_ctrl and stq_dp.
module sleep_timer_queue
   import stq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64,
   parameter int TIME_BITS   = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // now_us[47:0], proc_id[53:48],
                                             // sleep_seconds[69:54], zero[71:70]
   input  logic                  req_tuser,  // cmd: 0 tick, 1 sleep request
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // wake_valid[0], wake_proc[6:1],
                                             // queue_full[7], sleepers[14:8],
                                             // zero[15]
);

   stq_cmd_type  cmd;
   stq_stat_type stat;

   // sequencer: one request in flight, advance when the response slot frees
   stq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // datapath: wake time arithmetic, sorted shift queue, response register
   stq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TIME_BITS   (TIME_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ rtl/stq_ctrl.sv @@
// Sequencer for the sleep timer queue: steps a request through
// capture, multiply, add and insert; a tick retires in the multiply state. Depends on stq_pkg.
module stq_ctrl
   import stq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  stq_stat_type stat,
   output stq_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_ADD  = 2'd2;
   localparam logic [1:0] ST_INS  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (stat.is_sleep) begin
               state_in = ST_ADD;
            end else if (stat.out_free) begin
               cmd.tick_commit = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_ADD: begin
            state_in = ST_INS;
         end
         ST_INS: begin
            if (stat.out_free) begin
               cmd.ins_commit = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/stq_dp.sv @@
// Datapath of the sleep timer queue: request registers, wake time arithmetic,
// the sorted shift queue and the result register. Depends on stq_pkg.
module stq_dp
   import stq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64,
   parameter int TIME_BITS   = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  stq_cmd_type           cmd,
   output stq_stat_type          stat,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W   = ((TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W) + 1;
   localparam int NOW_X_W = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;
   localparam int CNT_X_W = (CNT_W > SLEEPERS_W) ? CNT_W : SLEEPERS_W;

   // request registers
   logic                 kind_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [ID_W-1:0]      id_ff;
   logic [SECS_W-1:0]    secs_ff;
   logic [DELAY_W-1:0]   delay_ff;
   logic [TIME_BITS-1:0] when_ff;

   // queue storage
   logic [TIME_BITS-1:0] wake_ff [QUEUE_DEPTH];
   logic [TIME_BITS-1:0] wake_in [QUEUE_DEPTH];
   logic [ID_W-1:0]      sid_ff  [QUEUE_DEPTH];
   logic [ID_W-1:0]      sid_in  [QUEUE_DEPTH];
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;

   logic                 rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [NOW_X_W-1:0]   now_x;
   logic [SUM_W-1:0]     sum;
   logic                 sat;
   logic [QUEUE_DEPTH-1:0] keep;
   logic                 full;
   logic                 due;
   logic                 do_pop;
   logic                 do_ins;
   logic [CNT_X_W-1:0]   cnt_x;
   logic [SLEEPERS_W-1:0] sleepers;
   logic [ID_W-1:0]      wake_proc;

   assign now_x = NOW_X_W'(req_tdata[NOW_W-1:0]);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_tuser;
         now_ff  <= now_x[TIME_BITS-1:0];
         id_ff   <= req_tdata[NOW_W +: ID_W];
         secs_ff <= req_tdata[NOW_W + ID_W +: SECS_W];
      end
   end

   // wake time: one multiply stage, then a saturating add stage
   assign sum = SUM_W'(now_ff) + SUM_W'(delay_ff);
   assign sat = |sum[SUM_W-1:TIME_BITS];

   always_ff @(posedge clock) begin
      delay_ff <= DELAY_W'(secs_ff) * DELAY_W'(USEC_PER_SEC);
      when_ff  <= sat ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
   end

   assign full   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign due    = (count_ff != '0) && (now_ff >= wake_ff[0]);
   assign do_pop = cmd.tick_commit && due;
   assign do_ins = cmd.ins_commit && !full;

   // entries that stay in place on insert: valid and strictly earlier
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         keep[i] = (CNT_W'(i) < count_ff) && (wake_ff[i] < when_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         wake_in[i] = wake_ff[i];
         sid_in[i]  = sid_ff[i];
      end
      if (do_pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            wake_in[i] = wake_ff[i+1];
            sid_in[i]  = sid_ff[i+1];
         end
      end else if (do_ins) begin
         if (!keep[0]) begin
            wake_in[0] = when_ff;
            sid_in[0]  = id_ff;
         end
         for (int i = 1; i < QUEUE_DEPTH; i++) begin
            if (!keep[i]) begin
               if (keep[i-1]) begin
                  wake_in[i] = when_ff;
                  sid_in[i]  = id_ff;
               end else begin
                  wake_in[i] = wake_ff[i-1];
                  sid_in[i]  = sid_ff[i-1];
               end
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end else if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         wake_ff[i] <= wake_in[i];
         sid_ff[i]  <= sid_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // result register
   assign cnt_x     = CNT_X_W'(count_in);
   assign sleepers  = cnt_x[SLEEPERS_W-1:0];
   assign wake_proc = do_pop ? sid_ff[0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.tick_commit || cmd.ins_commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tick_commit || cmd.ins_commit) begin
         rsp_data_ff <= {1'b0, sleepers, (cmd.ins_commit && full), wake_proc, do_pop};
      end
   end

   assign stat.is_sleep = (kind_ff == CMD_SLEEP);
   assign stat.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_data_ff;

endmodule
